/* rtl/kps_pkg.sv */
package kps_pkg;

  // Fixed geometry of the keypad matrix
  localparam int NUM_COLUMNS = 4;
  localparam int ROW_BITS    = 4;
  localparam int ROW_IDX_W   = $clog2(ROW_BITS);
  localparam int KEY_W       = 4;
  localparam int HELD_W      = 5;
  localparam int LIMIT_W     = 8;

  localparam logic [HELD_W-1:0]  KEY_NONE       = 5'd16;
  localparam logic [LIMIT_W-1:0] PRESCALE_RESET = 8'd5;

  // Item action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_PURGE = 1'b1;

  typedef logic [ROW_BITS-1:0] rows_t;

  // Key code by column and row of the single low line
  localparam logic [KEY_W-1:0] KEY_TABLE [NUM_COLUMNS][ROW_BITS] = '{
    '{4'd14, 4'd15, 4'd11, 4'd10},
    '{4'd13, 4'd9,  4'd6,  4'd3},
    '{4'd0,  4'd8,  4'd5,  4'd2},
    '{4'd12, 4'd7,  4'd4,  4'd1}
  };

  // Per-column decode status
  typedef struct packed {
    logic                 busy;
    logic                 hit;
    logic [ROW_IDX_W-1:0] row;
  } col_dec_t;

  typedef struct packed {
    logic                         action;
    rows_t [NUM_COLUMNS-1:0]      rows;
  } item_t;

  typedef struct packed {
    logic              key_waiting;
    logic [KEY_W-1:0]  buffered_key;
    logic              new_key;
    logic [HELD_W-1:0] last_key;
  } result_t;

endpackage

/* rtl/kps_if.sv */
interface kps_cmd_if import kps_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  rows_t rows_col1;
  rows_t rows_col2;
  rows_t rows_col3;
  rows_t rows_col4;

  modport source (output valid, action, rows_col1, rows_col2, rows_col3, rows_col4,
                  input ready);
  modport sink (input valid, action, rows_col1, rows_col2, rows_col3, rows_col4,
                output ready);
endinterface

interface kps_rsp_if import kps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              key_waiting;
  logic [KEY_W-1:0]  buffered_key;
  logic              new_key;
  logic [HELD_W-1:0] last_key;

  modport source (output valid, key_waiting, buffered_key, new_key, last_key,
                  input ready);
  modport sink (input valid, key_waiting, buffered_key, new_key, last_key,
                output ready);
endinterface

interface kps_cfg_if import kps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/kps_col_decode.sv */
module kps_col_decode import kps_pkg::*; (
  input  rows_t    rows,
  output col_dec_t dec
);

  logic [ROW_BITS-1:0] low;

  assign low = ~rows;

  // Flag any low line, a single low line, and its row index
  always_comb begin
    dec.busy = |low;
    dec.hit  = (low != '0) && ((low & (low - 1'b1)) == '0);
    dec.row  = '0;
    for (int r = 0; r < ROW_BITS; r++) begin
      if (low[r]) begin
        dec.row = ROW_IDX_W'(r);
      end
    end
  end

endmodule

/* rtl/kps_state.sv */
module kps_state import kps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  item_t              item,
  input  logic [LIMIT_W-1:0] limit,
  output result_t            result
);

  logic [LIMIT_W-1:0] prescale_count, prescale_count_next;
  logic [HELD_W-1:0]  held_key, held_key_next;
  logic [KEY_W-1:0]   key_buffer, key_buffer_next;
  logic               available_flag, available_flag_next;
  logic               stored;

  col_dec_t         dec     [NUM_COLUMNS];
  logic [KEY_W-1:0] col_key [NUM_COLUMNS];

  // Decode each column and look up its key code
  for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_col
    kps_col_decode u_dec (
      .rows (item.rows[c]),
      .dec  (dec[c])
    );
    assign col_key[c] = KEY_TABLE[c][dec[c].row];
  end

  // Scan the columns in order against the running held key
  always_comb begin
    logic any_busy;
    prescale_count_next = prescale_count;
    held_key_next       = held_key;
    key_buffer_next     = key_buffer;
    available_flag_next = available_flag;
    stored              = 1'b0;
    any_busy            = 1'b0;
    if (item.action == ACT_PURGE) begin
      available_flag_next = 1'b0;
    end else if (prescale_count >= limit) begin
      prescale_count_next = '0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        if (dec[c].busy) begin
          any_busy = 1'b1;
        end
        if (dec[c].hit && ({1'b0, col_key[c]} != held_key_next)) begin
          key_buffer_next     = col_key[c];
          held_key_next       = {1'b0, col_key[c]};
          available_flag_next = 1'b1;
          stored              = 1'b1;
        end
      end
      if (!any_busy) begin
        held_key_next = KEY_NONE;
      end
    end else begin
      prescale_count_next = prescale_count + 1'b1;
    end
  end

  assign result.key_waiting    = available_flag_next;
  assign result.buffered_key   = key_buffer_next;
  assign result.new_key        = stored;
  assign result.last_key       = held_key_next;

  // Commit state when the staged beat moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      held_key       <= KEY_NONE;
      available_flag <= 1'b0;
    end else if (advance) begin
      prescale_count <= prescale_count_next;
      held_key       <= held_key_next;
      available_flag <= available_flag_next;
    end
  end

  // Buffer holds no reset value
  always_ff @(posedge clk) begin
    if (advance) begin
      key_buffer <= key_buffer_next;
    end
  end

endmodule

/* rtl/matrix_keypad_scanner.sv */
// Keypad scanner: input register, combinational scan/update, result register.
// A beat taken on cmd waits in the input register until the result register is free.
// Throughput: one item per cycle while rsp does not stall; the column scan is a four-step chain
// inside the single stage between the input and result registers.
// Reset (rst, synchronous): prescaler 0, no key held, no key waiting,
// limit 5, both pipeline stages empty; the key buffer is not cleared.
module matrix_keypad_scanner import kps_pkg::*; (
  input logic      clk,
  input logic      rst,
  kps_cmd_if.sink  cmd,
  kps_rsp_if.source rsp,
  kps_cfg_if.sink  cfg
);

  logic               stg_valid;
  item_t              stg_item;
  logic               advance;
  logic [LIMIT_W-1:0] prescale_limit;
  result_t            result;
  logic               out_valid;
  result_t            out_data;

  assign advance   = stg_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !rst && (!stg_valid || advance);
  assign cfg.ready = !rst;

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_limit <= PRESCALE_RESET;
    end else if (cfg.valid) begin
      prescale_limit <= cfg.data;
    end
  end

  // Stage the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (cmd.ready) begin
      stg_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stg_item.action  <= cmd.action;
      stg_item.rows[0] <= cmd.rows_col1;
      stg_item.rows[1] <= cmd.rows_col2;
      stg_item.rows[2] <= cmd.rows_col3;
      stg_item.rows[3] <= cmd.rows_col4;
    end
  end

  kps_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stg_item),
    .limit   (prescale_limit),
    .result  (result)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.key_waiting    = out_data.key_waiting;
  assign rsp.buffered_key   = out_data.buffered_key;
  assign rsp.new_key        = out_data.new_key;
  assign rsp.last_key       = out_data.last_key;

`ifndef SYNTHESIS
  a_new_sets_avail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.new_key |-> rsp.key_waiting)
    else $error("new key without a key waiting");

  a_new_matches_held: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.new_key |-> rsp.last_key == {1'b0, rsp.buffered_key})
    else $error("stored key differs from held key");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.last_key <= KEY_NONE)
    else $error("held key out of range");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    stg_valid && out_valid && !rsp.ready |-> !cmd.ready)
    else $error("input taken while both stages are full");
`endif

endmodule

/* sim/tb_matrix_keypad_scanner.sv */
module tb_matrix_keypad_scanner;
  import kps_pkg::*;

  localparam int NUM_DIRECTED = 15;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // One keypad beat: action plus the row samples of columns 1 to 4
  typedef struct packed {
    logic  action;
    rows_t c1;
    rows_t c2;
    rows_t c3;
    rows_t c4;
  } scan_in_t;

  typedef struct packed {
    scan_in_t stim;
    logic     fixed;
    result_t  want;
  } dir_row_t;

  // Key code by column (1 to 4) and index of the single low row
  localparam logic [KEY_W-1:0] KEYPAD_CODES [4][4] = '{
    '{4'd14, 4'd15, 4'd11, 4'd10},
    '{4'd13, 4'd9,  4'd6,  4'd3},
    '{4'd0,  4'd8,  4'd5,  4'd2},
    '{4'd12, 4'd7,  4'd4,  4'd1}
  };

  // Directed beats, run with a limit of 0 so that every tick scans
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{ACT_TICK,  4'hE, 4'hF, 4'hF, 4'hF}, 1'b1, '{1'b1, 4'd14, 1'b1, 5'd14}},
    '{'{ACT_TICK,  4'hE, 4'hF, 4'hF, 4'hF}, 1'b1, '{1'b1, 4'd14, 1'b0, 5'd14}},
    '{'{ACT_PURGE, 4'h0, 4'h0, 4'h0, 4'h0}, 1'b1, '{1'b0, 4'd14, 1'b0, 5'd14}},
    '{'{ACT_TICK,  4'hF, 4'hF, 4'hF, 4'hF}, 1'b1, '{1'b0, 4'd14, 1'b0, KEY_NONE}},
    '{'{ACT_TICK,  4'h0, 4'h0, 4'h0, 4'h0}, 1'b1, '{1'b0, 4'd14, 1'b0, KEY_NONE}},
    '{'{ACT_TICK,  4'hF, 4'hF, 4'hF, 4'h7}, 1'b1, '{1'b1, 4'd1,  1'b1, 5'd1}},
    '{'{ACT_TICK,  4'hD, 4'hB, 4'h7, 4'hE}, 1'b0, '0},
    '{'{ACT_TICK,  4'hE, 4'hE, 4'hE, 4'hE}, 1'b0, '0},
    '{'{ACT_TICK,  4'hD, 4'hD, 4'hD, 4'hD}, 1'b0, '0},
    '{'{ACT_TICK,  4'hB, 4'hB, 4'hB, 4'hB}, 1'b0, '0},
    '{'{ACT_TICK,  4'h7, 4'h7, 4'h7, 4'h7}, 1'b0, '0},
    '{'{ACT_TICK,  4'hF, 4'hC, 4'hF, 4'hF}, 1'b0, '0},
    '{'{ACT_PURGE, 4'hF, 4'hF, 4'hF, 4'hF}, 1'b0, '0},
    '{'{ACT_TICK,  4'h7, 4'h7, 4'h7, 4'h7}, 1'b0, '0},
    '{'{ACT_TICK,  4'h5, 4'hA, 4'hF, 4'h3}, 1'b0, '0}
  };

  logic clk;
  logic rst;

  kps_cmd_if cmd_ch ();
  kps_rsp_if rsp_ch ();
  kps_cfg_if cfg_ch ();

  matrix_keypad_scanner u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Predicted scanner state
  logic [LIMIT_W-1:0] scan_limit;
  logic [LIMIT_W-1:0] tick_count;
  logic [HELD_W-1:0]  held_key_q;
  logic [KEY_W-1:0]   key_buf;
  logic               avail_q;

  result_t expected_scans [$];
  int      mismatches;
  int      idle_cycles;
  int      results_seen;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Key of one column, or none unless exactly one row is low
  function automatic logic [HELD_W-1:0] column_key(int col, rows_t rows);
    rows_t              low;
    logic [HELD_W-1:0]  k;
    low = ~rows;
    k   = KEY_NONE;
    if ($countones(low) == 1) begin
      for (int r = 0; r < ROW_BITS; r++) begin
        if (low[r]) k = {1'b0, KEYPAD_CODES[col][r]};
      end
    end
    return k;
  endfunction

  // Advance the predicted state by one beat and return its result
  function automatic result_t scan_predict(scan_in_t s);
    rows_t             cols [4];
    logic [HELD_W-1:0] k;
    logic              stored;
    int                seen;
    result_t           r;
    cols   = '{s.c1, s.c2, s.c3, s.c4};
    stored = 1'b0;
    seen   = 0;
    if (s.action == ACT_PURGE) begin
      avail_q = 1'b0;
    end else if (tick_count >= scan_limit) begin
      tick_count = '0;
      for (int c = 0; c < 4; c++) begin
        if (cols[c] != '1) begin
          seen++;
          k = column_key(c, cols[c]);
          if (k != KEY_NONE && k != held_key_q) begin
            key_buf    = k[KEY_W-1:0];
            held_key_q = k;
            avail_q    = 1'b1;
            stored     = 1'b1;
          end
        end
      end
      if (seen == 0) held_key_q = KEY_NONE;
    end else begin
      tick_count = tick_count + 1'b1;
    end
    r = '{avail_q, key_buf, stored, held_key_q};
    return r;
  endfunction

  // Random beat: mostly clean presses and releases, some purges and noise
  function automatic scan_in_t random_scan();
    scan_in_t s;
    int       pick;
    int       col;
    rows_t    one_hot;
    pick    = $urandom_range(0, 99);
    s       = '{ACT_TICK, 4'hF, 4'hF, 4'hF, 4'hF};
    one_hot = rows_t'(~(4'b0001 << $urandom_range(0, 3)));
    if (pick < 15) begin
      s = scan_in_t'($urandom);
      s.action = ACT_PURGE;
    end else if (pick < 40) begin
      s.action = ACT_TICK;
    end else if (pick < 80) begin
      col = $urandom_range(0, 3);
      case (col)
        0: s.c1 = one_hot;
        1: s.c2 = one_hot;
        2: s.c3 = one_hot;
        default: s.c4 = one_hot;
      endcase
    end else begin
      s = scan_in_t'($urandom);
      s.action = ACT_TICK;
    end
    return s;
  endfunction

  // Gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 30);
  endfunction

  // Present one beat, wait for it to be taken, queue its expected result
  task automatic send_scan(scan_in_t s, logic fixed, result_t want);
    result_t pred;
    @(negedge clk);
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= s.action;
    cmd_ch.rows_col1 <= s.c1;
    cmd_ch.rows_col2 <= s.c2;
    cmd_ch.rows_col3 <= s.c3;
    cmd_ch.rows_col4 <= s.c4;
    do @(posedge clk); while (!cmd_ch.ready);
    pred = scan_predict(s);
    expected_scans.push_back(fixed ? want : pred);
  endtask

  // Now and then, unless quiet, hold valid low for a random number of cycles between beats
  task automatic source_gap(bit quiet);
    int n;
    n = 0;
    if (!quiet && $urandom_range(0, 99) < 30) n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
  endtask

  // Write the prescale limit once every result is back
  task automatic write_prescale(logic [LIMIT_W-1:0] value);
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    scan_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    bit quiet;
    quiet = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) quiet = ~quiet;
      source_gap(quiet);
      send_scan(random_scan(), 1'b0, '0);
    end
    drop_valid();
  endtask

  // Receiver: stall at random, with quiet stretches
  initial begin
    int stall_left;
    bit quiet;
    stall_left   = 0;
    quiet        = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = gap_len();
      end
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.key_waiting, rsp_ch.buffered_key, rsp_ch.new_key,
              rsp_ch.last_key};
      results_seen++;
      if (expected_scans.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with nothing expected: avail=%0b key=%0d new=%0b held=%0d",
                   results_seen, got.key_waiting, got.buffered_key, got.new_key,
                   got.last_key);
      end else begin
        want = expected_scans.pop_front();
        if (got.key_waiting != want.key_waiting || got.buffered_key != want.buffered_key
            || got.new_key != want.new_key || got.last_key != want.last_key) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected avail=%0b key=%0d new=%0b held=%0d,",
                     results_seen, want.key_waiting, want.buffered_key, want.new_key,
                     want.last_key, " got avail=%0b key=%0d new=%0b held=%0d",
                     got.key_waiting, got.buffered_key, got.new_key, got.last_key);
        end
      end
    end
  end

  // End the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ACT_TICK;
    cmd_ch.rows_col1 = '1;
    cmd_ch.rows_col2 = '1;
    cmd_ch.rows_col3 = '1;
    cmd_ch.rows_col4 = '1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    scan_limit       = PRESCALE_RESET;
    tick_count       = '0;
    held_key_q       = KEY_NONE;
    key_buf          = '0;
    avail_q          = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Scan on every tick so the first beat stores a key
    write_prescale(8'd0);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_scan(DIRECTED[i].stim, DIRECTED[i].fixed, DIRECTED[i].want);
      source_gap(1'b0);
    end
    drop_valid();
    random_phase(700);

    // Widest interval: only a couple of scans in this phase
    write_prescale(8'd255);
    random_phase(600);

    // Lower the limit below the running count
    write_prescale(8'd1);
    random_phase(400);

    write_prescale(8'd3);
    random_phase(300);

    write_prescale(PRESCALE_RESET);
    random_phase(200);

    // Drain outstanding results, then let the pipeline settle
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
